@@ hw/rtl/kns_pkg.sv @@
// shared constants and ranking function for the k-nearest selector
`default_nettype none
package kns_pkg;

    localparam int DIST_W     = 32;
    localparam int TIE_W      = 31;
    localparam int WT_W       = 16;
    localparam int WSUM_W     = 30;
    localparam int TARGET_W   = 24;
    localparam int KCNT_W     = 6;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DEF_CAPACITY   = 32;
    localparam int DEF_INDEX_BITS = 20;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INCLUDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDCLS = 3'd4;

    // selection modes
    localparam logic [MODE_W-1:0] MODE_ALL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KBEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd2;

    // request types
    localparam logic REQ_OFFER  = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // a ranks before b; with or_equal set a full tie also counts
    function automatic logic ranks_before(
        input logic [DIST_W-1:0] dist_a,
        input logic [TIE_W-1:0]  tie_a,
        input logic [DIST_W-1:0] dist_b,
        input logic [TIE_W-1:0]  tie_b,
        input logic              or_equal
    );
        logic res;
        if (dist_a != dist_b)
        begin
            res = dist_a < dist_b;
        end
        else
        begin
            res = or_equal ? (tie_a <= tie_b) : (tie_a < tie_b);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/kns_ram.sv @@
// generic single-port-write, registered-read ram
`default_nettype none
module kns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/k_nearest_selector.sv @@
// top level of the k-nearest selector: sorted entry ram and its sequencer
//
// Usage: pulse start with the request fields while busy is low. req_type 0
// offers a candidate, req_type 1 finishes and reads the kept set out.
// Registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle; the block itself does not enforce it.
// The kept set lives sorted (best first) in one ram of CAPACITY+1 words.
// An offer shifts worse entries up one place at a time, each move a ram
// read and then a compare and write back; a full set first has its worst
// entry fetched and compared, and weighted mode ends with a weight check.
// A dropped candidate leaves the block idle. A finish streams one result
// word per cycle on strobe, best first, the first word passing through the
// readout state, the registered ram read and the output register; an empty
// set gives a single word with out_valid low. The set is cleared after the
// run, the busy flag drops with the last word. Results cannot be held off.
// Reset empties the set, clears the overflow flag and loads default
// register values; the ram contents need no clearing.
`default_nettype none
module k_nearest_selector #(
    parameter int CAPACITY   = kns_pkg::DEF_CAPACITY,
    parameter int INDEX_BITS = kns_pkg::DEF_INDEX_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [kns_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kns_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              req_type,
    input  wire logic [INDEX_BITS-1:0]             cand_index,
    input  wire logic [kns_pkg::DIST_W-1:0]        cand_distance,
    input  wire logic [kns_pkg::TIE_W-1:0]         tie_key,
    input  wire logic [kns_pkg::WT_W-1:0]          cand_weight,
    input  wire logic                              class_missing,
    // result
    output logic                                   strobe,
    output logic [INDEX_BITS-1:0]                  out_index,
    output logic [kns_pkg::DIST_W-1:0]             out_distance,
    output logic                                   out_valid,
    output logic                                   last,
    output logic                                   overflowed
);
    import kns_pkg::*;

    localparam int DEPTH = CAPACITY + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(CAPACITY + 2);
    localparam int EW    = INDEX_BITS + DIST_W + TIE_W + WT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WCHK  = 7'b0000010,
        ST_INS   = 7'b0000100,
        ST_CMP   = 7'b0001000,
        ST_POST  = 7'b0010000,
        ST_RDOUT = 7'b0100000,
        ST_DRAIN = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [MODE_W-1:0]   mode_reg;
    logic [KCNT_W-1:0]   k_reg;
    logic [TARGET_W-1:0] target_reg;
    logic                include_reg;
    logic                needcls_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_KBEST;
            k_reg       <= KCNT_W'(1);
            target_reg  <= TARGET_W'(256);
            include_reg <= 1'b1;
            needcls_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[MODE_W-1:0];
                REG_K:       k_reg       <= cfg_data[KCNT_W-1:0];
                REG_TARGET:  target_reg  <= cfg_data[TARGET_W-1:0];
                REG_INCLUDE: include_reg <= cfg_data[0];
                REG_NEEDCLS: needcls_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // set state
    logic [CW-1:0]     count_reg, count_next;
    logic [WSUM_W-1:0] sum_reg, sum_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [WT_W-1:0]   worst_reg, worst_next;
    logic              first_reg, first_next;
    logic              pend_reg, pend_next;
    logic              lpend_reg, lpend_next;

    // candidate word
    logic [INDEX_BITS-1:0] c_idx_reg;
    logic [DIST_W-1:0]     c_dist_reg;
    logic [TIE_W-1:0]      c_tie_reg;
    logic [WT_W-1:0]       c_wt_reg;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata, cand_word;

    kns_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // fields of the word read back
    logic [INDEX_BITS-1:0] r_idx;
    logic [DIST_W-1:0]     r_dist;
    logic [TIE_W-1:0]      r_tie;
    logic [WT_W-1:0]       r_wt;
    assign {r_idx, r_dist, r_tie, r_wt} = ram_rdata;
    assign cand_word = {c_idx_reg, c_dist_reg, c_tie_reg, c_wt_reg};

    // effective k for count mode
    logic [CW:0] k_eff;
    always_comb
    begin
        priority if (k_reg == '0)
        begin
            k_eff = (CW+1)'(1);
        end
        else if ((CW+1+KCNT_W)'(k_reg) > (CW+1+KCNT_W)'(CAPACITY))
        begin
            k_eff = (CW+1)'(CAPACITY);
        end
        else
        begin
            k_eff = (CW+1)'(k_reg);
        end
    end

    logic accept, drop_cand, is_weight, cand_first;
    logic [WSUM_W-1:0] sum_less;
    logic [CW-1:0]     count_m1;
    assign accept    = start && !busy;
    assign drop_cand = (needcls_reg && class_missing)
                       || (!include_reg && cand_distance == '0);
    assign is_weight = (mode_reg == MODE_WEIGHT);
    assign count_m1  = count_reg - CW'(1);
    assign sum_less  = sum_reg - WSUM_W'(worst_reg);
    assign cand_first = ranks_before(c_dist_reg, c_tie_reg, r_dist, r_tie, 1'b0);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        worst_next = worst_reg;
        first_next = first_reg;
        pend_next  = 1'b0;
        lpend_next = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = cand_word;
        ram_raddr  = count_m1[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = count_m1[AW-1:0];
                if (accept)
                begin
                    first_next = 1'b1;
                    pos_next   = count_reg[AW-1:0];
                    if (req_type == REQ_FINISH)
                    begin
                        if (count_reg == '0)
                        begin
                            count_next = '0;
                            sum_next   = '0;
                            ovf_next   = 1'b0;
                        end
                        else
                        begin
                            pos_next   = '0;
                            state_next = ST_RDOUT;
                        end
                    end
                    else if (!drop_cand)
                    begin
                        priority if (mode_reg == MODE_ALL)
                        begin
                            if (count_reg < CAP_C)
                            begin
                                state_next = ST_INS;
                            end
                            else
                            begin
                                ovf_next   = 1'b1;
                                state_next = ST_WCHK;
                            end
                        end
                        else if (is_weight)
                        begin
                            state_next = ST_INS;
                        end
                        else if ((CW+1)'(count_reg) < k_eff)
                        begin
                            state_next = ST_INS;
                        end
                        else
                        begin
                            state_next = ST_WCHK;
                        end
                    end
                end
            end
            ST_WCHK:
            begin
                if (ranks_before(c_dist_reg, c_tie_reg, r_dist, r_tie,
                                 mode_reg != MODE_ALL))
                begin
                    count_next = count_m1;
                    sum_next   = sum_reg - WSUM_W'(r_wt);
                    pos_next   = count_m1[AW-1:0];
                    state_next = ST_INS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_INS:
            begin
                ram_raddr = pos_reg - AW'(1);
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = cand_word;
                    worst_next = first_reg ? c_wt_reg : worst_reg;
                    count_next = count_reg + CW'(1);
                    sum_next   = sum_reg + WSUM_W'(c_wt_reg);
                    state_next = is_weight ? ST_POST : ST_IDLE;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                ram_we     = 1'b1;
                first_next = 1'b0;
                if (cand_first)
                begin
                    // move the stored word one place up
                    ram_wdata  = ram_rdata;
                    worst_next = first_reg ? r_wt : worst_reg;
                    pos_next   = pos_reg - AW'(1);
                    state_next = ST_INS;
                end
                else
                begin
                    ram_wdata  = cand_word;
                    worst_next = first_reg ? c_wt_reg : worst_reg;
                    count_next = count_reg + CW'(1);
                    sum_next   = sum_reg + WSUM_W'(c_wt_reg);
                    state_next = is_weight ? ST_POST : ST_IDLE;
                end
            end
            ST_POST:
            begin
                // weighted mode trim of the worst entry
                priority if (sum_less >= WSUM_W'(target_reg))
                begin
                    count_next = count_m1;
                    sum_next   = sum_less;
                end
                else if (count_reg > CAP_C)
                begin
                    count_next = count_m1;
                    sum_next   = sum_less;
                    ovf_next   = 1'b1;
                end
                else
                begin
                    count_next = count_reg;
                end
                state_next = ST_IDLE;
            end
            ST_RDOUT:
            begin
                ram_raddr  = pos_reg;
                pend_next  = 1'b1;
                lpend_next = (CW'(pos_reg) == count_m1);
                pos_next   = pos_reg + AW'(1);
                if (CW'(pos_reg) == count_m1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                count_next = '0;
                sum_next   = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
            first_reg <= 1'b0;
            pend_reg  <= 1'b0;
            lpend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
            first_reg <= first_next;
            pend_reg  <= pend_next;
            lpend_reg <= lpend_next;
        end
    end

    // candidate capture and worst weight
    always_ff @(posedge clk)
    begin
        worst_reg <= worst_next;
        if (accept)
        begin
            c_idx_reg  <= cand_index;
            c_dist_reg <= cand_distance;
            c_tie_reg  <= tie_key;
            c_wt_reg   <= cand_weight;
        end
    end

    // result word
    logic                  strobe_reg;
    logic                  last_reg;
    logic                  valid_reg;
    logic                  ovfo_reg;
    logic [INDEX_BITS-1:0] idx_o_reg;
    logic [DIST_W-1:0]     dist_o_reg;
    logic                  empty_fin;
    assign empty_fin = accept && req_type == REQ_FINISH && count_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= pend_reg || empty_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            idx_o_reg  <= r_idx;
            dist_o_reg <= r_dist;
            valid_reg  <= 1'b1;
            last_reg   <= lpend_reg;
            ovfo_reg   <= ovf_reg;
        end
        else if (empty_fin)
        begin
            idx_o_reg  <= '0;
            dist_o_reg <= '0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b1;
            ovfo_reg   <= ovf_reg;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign strobe       = strobe_reg;
    assign out_index    = idx_o_reg;
    assign out_distance = dist_o_reg;
    assign out_valid    = valid_reg;
    assign last         = last_reg;
    assign overflowed   = ovfo_reg;

endmodule
`default_nettype wire

@@ hw/rtl/kns_checker.sv @@
// port-level checks of the k-nearest selector and their binding
`default_nettype none
module kns_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic req_type,
    input wire logic strobe,
    input wire logic out_valid,
    input wire logic last
);
    import kns_pkg::*;

    // a readout run has no gaps
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("readout run broke before last word");

    // an empty report is flagged as the last word of its run
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !out_valid |-> last)
        else $error("empty report without last");

    // an offer never produces a word
    a_offer_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == REQ_OFFER |=> !strobe)
        else $error("word after an offer");

    // a word that is not the last keeps the block busy
    a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("idle in the middle of a readout run");

endmodule

bind k_nearest_selector kns_checker u_kns_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .strobe    (strobe),
    .out_valid (out_valid),
    .last      (last)
);
`default_nettype wire
